/* design/wfc_pkg.sv */
package wfc_pkg;

    // request codes
    localparam logic [2:0] REQ_START_ENC = 3'd0;
    localparam logic [2:0] REQ_START_DEC = 3'd1;
    localparam logic [2:0] REQ_BODY      = 3'd2;
    localparam logic [2:0] REQ_END       = 3'd3;
    localparam logic [2:0] REQ_ICV       = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_ICV    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;
    localparam logic [1:0] CFG_KEY_IDX  = 2'd3;

    localparam logic [3:0]  MAX_KEY_BYTES = 4'd13;
    localparam logic [3:0]  KEY_LEN_RESET = 4'd5;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] WEAK_MIN      = 32'h0003ff00;
    localparam logic [31:0] WEAK_MASK     = 32'h00f8ff00;
    localparam logic [31:0] WEAK_MATCH    = 32'h0000ff00;
    localparam logic [31:0] WEAK_STEP     = 32'h00000100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SRD_I,
        ST_SRD_J,
        ST_SWR_I,
        ST_SWR_J,
        ST_HDR,
        ST_KRD_I,
        ST_KRD_J,
        ST_KWR_I,
        ST_KWR_J,
        ST_KRD_T,
        ST_KOUT
    } t_state;

    // fold one byte into a reflected crc-32
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* design/wfc_if.sv */
interface wfc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic [31:0] random_value;
    logic [23:0] received_iv;

    modport source(output valid, req_type, data_byte, random_value, received_iv,
                   input ready);
    modport sink(input valid, req_type, data_byte, random_value, received_iv,
                 output ready);
endinterface

interface wfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       check_status;
    logic       is_last;

    modport source(output valid, out_byte, byte_kind, check_status, is_last,
                   input ready);
    modport sink(input valid, out_byte, byte_kind, check_status, is_last,
                 output ready);
endinterface

/* design/wep_frame_crypt.sv */
// WEP frame body cipher (RC4 keystream, CRC-32 ICV). One request beat is taken at a
// time while the block is idle; a finished result waits in an output register.
// The 256-byte RC4 permutation lives in one synchronous memory with one write
// and one read port, so every step of the cipher is a sequence of single-entry
// accesses: a start request fills the permutation, runs the key schedule (read
// S[i], read S[j], write both, per step) and then, for encryption, sends 4 header
// beats; a body or received ICV byte takes 6 cipher steps; end of body while
// encrypting sends its 4 ICV beats; a request that does nothing returns to idle.
// An output stall holds the block until the result register is free.
module wep_frame_crypt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [63:0]        i_cfg_data,
    wfc_in_if.sink             i_in,
    wfc_out_if.source          o_out
);

    // configuration
    logic [63:0] r_key_lo;
    logic [39:0] r_key_hi;
    logic [3:0]  r_key_len;
    logic [1:0]  r_key_idx;

    // frame state
    wfc_pkg::t_state r_state, n_state;
    logic [2:0]  r_req;
    logic [7:0]  r_data;
    logic [23:0] r_iv24;
    logic [31:0] r_ivc;
    logic        r_dec;
    logic [7:0]  r_i, r_j, r_n, r_si, r_sj;
    logic [3:0]  r_sk;
    logic [1:0]  r_cnt;
    logic [31:0] r_crc;
    logic [31:0] r_icv;
    logic [2:0]  r_icnt;

    // output register
    logic       r_ov;
    logic [7:0] r_ob;
    logic [1:0] r_ok;
    logic       r_os;
    logic       r_ol;

    // permutation memory
    logic [7:0] r_mem [256];
    logic [7:0] r_rdata;
    logic       mem_we;
    logic [7:0] mem_wa, mem_wd, mem_ra;

    logic        accept, out_free, emit;
    logic [7:0]  e_byte;
    logic [1:0]  e_kind;
    logic        e_stat, e_last;
    logic [3:0]  klen;
    logic [3:0]  sk_wrap;
    logic [7:0]  seed;
    logic [3:0]  kpos;
    logic [103:0] key_all;
    logic [31:0] iv_pick, iv_fix;
    logic [7:0]  j_sched, j_ks;
    logic [31:0] icv_inv;
    logic [31:0] icv_new;
    logic [2:0]  icnt_new;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == wfc_pkg::ST_IDLE);

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_ob;
    assign o_out.byte_kind    = r_ok;
    assign o_out.check_status = r_os;
    assign o_out.is_last      = r_ol;

    // seed byte for the schedule: iv bytes then key bytes
    assign klen    = (r_key_len > wfc_pkg::MAX_KEY_BYTES) ? wfc_pkg::MAX_KEY_BYTES : r_key_len;
    assign sk_wrap = klen + 4'd2;
    assign key_all = {r_key_hi, r_key_lo};
    assign kpos    = r_sk - 4'd3;
    always_comb begin
        if (r_sk < 4'd3) begin
            seed = r_iv24[r_sk[1:0]*8 +: 8];
        end else begin
            seed = key_all[kpos*8 +: 8];
        end
    end
    assign j_sched = r_j + r_rdata + seed;
    assign j_ks    = r_j + r_rdata;

    // iv choice with weak iv skip
    assign iv_pick = (r_ivc != 32'd0) ? r_ivc : i_in.random_value;
    assign iv_fix  = (iv_pick >= wfc_pkg::WEAK_MIN &&
                      (iv_pick & wfc_pkg::WEAK_MASK) == wfc_pkg::WEAK_MATCH)
                     ? iv_pick + wfc_pkg::WEAK_STEP : iv_pick;

    // received icv capture
    assign icv_inv  = ~r_crc;
    always_comb begin
        icv_new = r_icv;
        icv_new[r_icnt[1:0]*8 +: 8] = r_data ^ r_rdata;
    end
    assign icnt_new = r_icnt + 3'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wfc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in.req_type)
                        wfc_pkg::REQ_START_ENC, wfc_pkg::REQ_START_DEC:
                            n_state = wfc_pkg::ST_INIT;
                        wfc_pkg::REQ_BODY: n_state = wfc_pkg::ST_KRD_I;
                        wfc_pkg::REQ_END:
                            n_state = r_dec ? wfc_pkg::ST_IDLE : wfc_pkg::ST_KRD_I;
                        wfc_pkg::REQ_ICV:
                            n_state = r_dec ? wfc_pkg::ST_KRD_I : wfc_pkg::ST_IDLE;
                        default: n_state = wfc_pkg::ST_IDLE;
                    endcase
                end
            end
            wfc_pkg::ST_INIT: if (r_n == 8'd255) n_state = wfc_pkg::ST_SRD_I;
            wfc_pkg::ST_SRD_I: n_state = wfc_pkg::ST_SRD_J;
            wfc_pkg::ST_SRD_J: n_state = wfc_pkg::ST_SWR_I;
            wfc_pkg::ST_SWR_I: n_state = wfc_pkg::ST_SWR_J;
            wfc_pkg::ST_SWR_J: begin
                if (r_n != 8'd255) begin
                    n_state = wfc_pkg::ST_SRD_I;
                end else begin
                    n_state = r_dec ? wfc_pkg::ST_IDLE : wfc_pkg::ST_HDR;
                end
            end
            wfc_pkg::ST_HDR: if (out_free && r_cnt == 2'd3) n_state = wfc_pkg::ST_IDLE;
            wfc_pkg::ST_KRD_I: n_state = wfc_pkg::ST_KRD_J;
            wfc_pkg::ST_KRD_J: n_state = wfc_pkg::ST_KWR_I;
            wfc_pkg::ST_KWR_I: n_state = wfc_pkg::ST_KWR_J;
            wfc_pkg::ST_KWR_J: n_state = wfc_pkg::ST_KRD_T;
            wfc_pkg::ST_KRD_T: n_state = wfc_pkg::ST_KOUT;
            wfc_pkg::ST_KOUT: begin
                if (out_free) begin
                    if (r_req == wfc_pkg::REQ_END && r_cnt != 2'd3) begin
                        n_state = wfc_pkg::ST_KRD_I;
                    end else begin
                        n_state = wfc_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = wfc_pkg::ST_IDLE;
        endcase
    end

    // memory access and result outputs
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_n;
        mem_wd = r_n;
        mem_ra = r_n;
        emit   = 1'b0;
        e_byte = 8'd0;
        e_kind = wfc_pkg::KIND_HDR;
        e_stat = 1'b0;
        e_last = 1'b0;
        case (r_state)
            wfc_pkg::ST_INIT: mem_we = 1'b1;
            wfc_pkg::ST_SRD_J: mem_ra = j_sched;
            wfc_pkg::ST_SWR_I: begin
                mem_we = 1'b1;
                mem_wd = r_rdata;
            end
            wfc_pkg::ST_SWR_J: begin
                mem_we = 1'b1;
                mem_wa = r_j;
                mem_wd = r_si;
            end
            wfc_pkg::ST_HDR: begin
                emit   = out_free;
                e_byte = (r_cnt == 2'd3) ? {r_key_idx, 6'd0} : r_iv24[r_cnt*8 +: 8];
                e_last = (r_cnt == 2'd3);
            end
            wfc_pkg::ST_KRD_I: mem_ra = r_i + 8'd1;
            wfc_pkg::ST_KRD_J: mem_ra = j_ks;
            wfc_pkg::ST_KWR_I: begin
                mem_we = 1'b1;
                mem_wa = r_i;
                mem_wd = r_rdata;
            end
            wfc_pkg::ST_KWR_J: begin
                mem_we = 1'b1;
                mem_wa = r_j;
                mem_wd = r_si;
            end
            wfc_pkg::ST_KRD_T: mem_ra = r_si + r_sj;
            wfc_pkg::ST_KOUT: begin
                // keep the keystream byte on the read port while stalled
                mem_ra = r_si + r_sj;
                case (r_req)
                    wfc_pkg::REQ_BODY: begin
                        emit   = out_free;
                        e_byte = r_data ^ r_rdata;
                        e_kind = wfc_pkg::KIND_BODY;
                        e_last = 1'b1;
                    end
                    wfc_pkg::REQ_END: begin
                        emit   = out_free;
                        e_byte = icv_inv[r_cnt*8 +: 8] ^ r_rdata;
                        e_kind = wfc_pkg::KIND_ICV;
                        e_last = (r_cnt == 2'd3);
                    end
                    default: begin
                        emit   = out_free && (icnt_new >= 3'd4);
                        e_kind = wfc_pkg::KIND_STATUS;
                        e_stat = (icv_new != icv_inv);
                        e_last = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // permutation memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= 64'd0;
            r_key_hi  <= 40'd0;
            r_key_len <= wfc_pkg::KEY_LEN_RESET;
            r_key_idx <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                wfc_pkg::CFG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                wfc_pkg::CFG_KEY_HIGH: r_key_hi  <= i_cfg_data[39:0];
                wfc_pkg::CFG_KEY_LEN:  r_key_len <= i_cfg_data[3:0];
                wfc_pkg::CFG_KEY_IDX:  r_key_idx <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob <= e_byte;
            r_ok <= e_kind;
            r_os <= e_stat;
            r_ol <= e_last;
        end
    end

    // cipher state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfc_pkg::ST_IDLE;
            r_i     <= 8'd0;
            r_j     <= 8'd0;
            r_crc   <= '1;
            r_ivc   <= 32'd0;
            r_dec   <= 1'b0;
            r_icv   <= 32'd0;
            r_icnt  <= 3'd0;
            r_n     <= 8'd0;
            r_sk    <= 4'd0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                wfc_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_req  <= i_in.req_type;
                        r_data <= i_in.data_byte;
                        r_cnt  <= 2'd0;
                        case (i_in.req_type)
                            wfc_pkg::REQ_START_ENC, wfc_pkg::REQ_START_DEC: begin
                                if (i_in.req_type == wfc_pkg::REQ_START_ENC) begin
                                    r_iv24 <= iv_fix[23:0];
                                    r_ivc  <= iv_fix + 32'd1;
                                    r_dec  <= 1'b0;
                                end else begin
                                    r_iv24 <= i_in.received_iv;
                                    r_dec  <= 1'b1;
                                end
                                r_i    <= 8'd0;
                                r_j    <= 8'd0;
                                r_crc  <= '1;
                                r_icv  <= 32'd0;
                                r_icnt <= 3'd0;
                                r_n    <= 8'd0;
                                r_sk   <= 4'd0;
                            end
                            wfc_pkg::REQ_END: begin
                                if (r_dec) begin
                                    r_icv  <= 32'd0;
                                    r_icnt <= 3'd0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                wfc_pkg::ST_INIT: r_n <= r_n + 8'd1;
                wfc_pkg::ST_SRD_J: begin
                    r_si <= r_rdata;
                    r_j  <= j_sched;
                    r_sk <= (r_sk == sk_wrap) ? 4'd0 : r_sk + 4'd1;
                end
                wfc_pkg::ST_SWR_J: begin
                    r_n <= r_n + 8'd1;
                    if (r_n == 8'd255) r_j <= 8'd0;
                end
                wfc_pkg::ST_HDR: if (out_free) r_cnt <= r_cnt + 2'd1;
                wfc_pkg::ST_KRD_I: r_i <= r_i + 8'd1;
                wfc_pkg::ST_KRD_J: begin
                    r_si <= r_rdata;
                    r_j  <= j_ks;
                end
                wfc_pkg::ST_KWR_I: r_sj <= r_rdata;
                wfc_pkg::ST_KOUT: begin
                    if (out_free) begin
                        case (r_req)
                            wfc_pkg::REQ_BODY:
                                r_crc <= wfc_pkg::crc_fold(r_crc,
                                         r_dec ? (r_data ^ r_rdata) : r_data);
                            wfc_pkg::REQ_END: r_cnt <= r_cnt + 2'd1;
                            default: begin
                                r_icv  <= icv_new;
                                r_icnt <= (icnt_new >= 3'd4) ? 3'd0 : icnt_new;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/wfc_checker.sv */
module wfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_kind,
    input logic       i_out_status,
    input logic       i_out_last
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result beat after reset");

    // a pending non-final beat means the request is still in progress
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("request taken mid run");

    // status flag only on status beats; a status beat carries a zero byte and is last
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == wfc_pkg::KIND_STATUS || !i_out_status) &&
                        (i_out_kind != wfc_pkg::KIND_STATUS ||
                         (i_out_byte == 8'd0 && i_out_last)))
        else $error("bad status beat");

endmodule

bind wep_frame_crypt wfc_checker u_wfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_out_kind   (o_out.byte_kind),
    .i_out_status (o_out.check_status),
    .i_out_last   (o_out.is_last)
);
